@@ design/vrmf_pkg.sv @@
// ----------------------------------------------------------------------------
// vrmf_pkg
// Shared types and constants for the vector rename map and free list block.
// ----------------------------------------------------------------------------
package vrmf_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int RENAMED_SLOTS_DEF = 64;
  localparam int PHYS_REGS_DEF     = 64;
  localparam int PRESET_SLOTS_DEF  = 32;

  // Fixed field widths of the item and result ports.
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 6;
  localparam int OPND_W    = 16;
  localparam int CNT_W     = 16;
  localparam int RES_REG_W = 6;
  // Widest physical register number (PHYS_REGS at most 256).
  localparam int REG_W     = 8;

  typedef logic [REG_W-1:0] phys_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP_READ     = 3'd0,
    CMD_MAP_WRITE    = 3'd1,
    CMD_ALLOCATE     = 3'd2,
    CMD_RELEASE      = 3'd3,
    CMD_COUNTER_ADD  = 3'd4,
    CMD_COUNTER_READ = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REFUSED = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // One command item as it moves through the execute stage.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_index;
    logic              no_register;
    logic [OPND_W-1:0] operand;
  } item_t;

  // Answer of the slot table (map entries and commit counters).
  typedef struct packed {
    phys_t            map_reg;
    logic             mapped;
    logic [CNT_W-1:0] cval;
    status_t          status;
  } slot_rsp_t;

  // Answer of the free list.
  typedef struct packed {
    phys_t   pop_reg;
    logic    empty;
    status_t status;
  } fl_rsp_t;

endpackage

@@ design/vrmf_ram.sv @@
// ----------------------------------------------------------------------------
// vrmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vrmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/vrmf_free_list.sv @@
// ----------------------------------------------------------------------------
// vrmf_free_list
// FIFO of free physical registers in RAM, with head, tail, count and a
// presence bitmap for duplicate checks.
// ----------------------------------------------------------------------------
module vrmf_free_list #(
  parameter int PHYS_REGS = vrmf_pkg::PHYS_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic              fire,
  input  vrmf_pkg::item_t   item,
  output vrmf_pkg::fl_rsp_t rsp
);

  localparam int PW = $clog2(PHYS_REGS);
  localparam int CW = $clog2(PHYS_REGS + 1);
  localparam logic [PW-1:0] LAST_POS   = PW'(PHYS_REGS - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(PHYS_REGS);
  localparam logic [CW-1:0] NEAR_FULL  = CW'(PHYS_REGS - 1);

  logic [PW-1:0]        head;
  logic [PW-1:0]        tail;
  logic [CW-1:0]        count;
  logic [PHYS_REGS-1:0] in_free;
  logic [PHYS_REGS-1:0] q_written;
  logic                 fwd_hit;
  logic [PW-1:0]        fwd_reg;

  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic [CW-1:0] count_next;
  logic [PW-1:0] q_data;
  logic [PW-1:0] q_head;
  logic [PW-1:0] op_reg;
  logic [PW-1:0] rd_addr;
  logic          alloc_cmd;
  logic          release_cmd;
  logic          reg_ok;
  logic          do_pop;
  logic          do_push;

  always_comb begin
    alloc_cmd   = item.command == vrmf_pkg::CMD_ALLOCATE;
    release_cmd = (item.command == vrmf_pkg::CMD_RELEASE) && !item.no_register;
    reg_ok      = item.operand < 16'(PHYS_REGS);
    op_reg      = item.operand[PW-1:0];
    // An entry never written still holds its own position.
    q_head      = fwd_hit ? fwd_reg : (q_written[head] ? q_data : head);
    do_pop      = alloc_cmd && (count != '0);
    do_push     = release_cmd && reg_ok && (count < NEAR_FULL) && !in_free[op_reg];

    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (do_pop) begin
      head_next  = (head == LAST_POS) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
    if (do_push) begin
      tail_next  = (tail == LAST_POS) ? '0 : tail + 1'b1;
      count_next = count + 1'b1;
    end

    rsp.status = vrmf_pkg::ST_OK;
    if (alloc_cmd && !do_pop) begin
      rsp.status = vrmf_pkg::ST_EMPTY;
    end else if (release_cmd && !reg_ok) begin
      rsp.status = vrmf_pkg::ST_RANGE;
    end else if (release_cmd && !do_push) begin
      rsp.status = vrmf_pkg::ST_REFUSED;
    end
    rsp.pop_reg = do_pop ? vrmf_pkg::phys_t'(q_head) : '0;
    rsp.empty   = count_next == '0;

    // Read the head as it stands after the item now finishing.
    rd_addr = fire ? head_next : head;
  end

  vrmf_ram #(
    .WIDTH (PW),
    .DEPTH (PHYS_REGS)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (fire && do_push),
    .wr_addr (tail),
    .wr_data (op_reg),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (q_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= FULL_COUNT;
      in_free   <= '1;
      q_written <= '0;
      fwd_hit   <= 1'b0;
    end else begin
      if (fire) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
        if (do_pop) begin
          in_free[q_head] <= 1'b0;
        end
        if (do_push) begin
          in_free[op_reg] <= 1'b1;
          q_written[tail] <= 1'b1;
        end
      end
      if (rd_en) begin
        fwd_hit <= fire && do_push && (tail == head_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_reg <= op_reg;
    end
  end

`ifndef NO_ASSERTIONS
  a_bitmap_count: assert property (@(posedge clk) disable iff (rst)
    $countones(in_free) == int'(count))
    else $error("free bitmap disagrees with free count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("free count above register count");

  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_COUNT) |-> head == tail)
    else $error("head and tail apart on empty or full list");

  a_pop_present: assert property (@(posedge clk) disable iff (rst)
    (fire && do_pop) |-> in_free[q_head])
    else $error("popped register not marked free");
`endif

endmodule

@@ design/vrmf_slot_table.sv @@
// ----------------------------------------------------------------------------
// vrmf_slot_table
// Per-slot RAM holding the map entry and commit counter, read-modify-write
// with a forwarding register for back-to-back access to one slot.
// ----------------------------------------------------------------------------
module vrmf_slot_table #(
  parameter int RENAMED_SLOTS = vrmf_pkg::RENAMED_SLOTS_DEF,
  parameter int PHYS_REGS     = vrmf_pkg::PHYS_REGS_DEF,
  parameter int PRESET_SLOTS  = vrmf_pkg::PRESET_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [vrmf_pkg::IDX_W-1:0] rd_idx,
  input  logic                       fire,
  input  vrmf_pkg::item_t            item,
  output vrmf_pkg::slot_rsp_t        rsp
);

  localparam int SW = $clog2(RENAMED_SLOTS);
  localparam int PW = $clog2(PHYS_REGS);
  localparam int WW = vrmf_pkg::CNT_W + PW;

  logic [RENAMED_SLOTS-1:0] map_valid;
  logic [RENAMED_SLOTS-1:0] cnt_written;
  logic                     fwd_hit;
  logic [WW-1:0]            fwd_word;

  logic [SW-1:0]              addr;
  logic [SW-1:0]              rd_addr;
  logic [WW-1:0]              rd_data;
  logic [WW-1:0]              word;
  logic [WW-1:0]              wr_word;
  logic [vrmf_pkg::CNT_W-1:0] cnt_eff;
  logic [vrmf_pkg::CNT_W-1:0] sum;
  logic [PW-1:0]              op_reg;
  logic                       idx_ok;
  logic                       reg_ok;
  logic                       wr_map;
  logic                       wr_cnt;
  logic                       wr_en;

  always_comb begin
    addr    = SW'(item.entry_index);
    rd_addr = SW'(rd_idx);
    idx_ok  = 9'(item.entry_index) < 9'(RENAMED_SLOTS);
    reg_ok  = item.operand < 16'(PHYS_REGS);
    op_reg  = item.operand[PW-1:0];
    word    = fwd_hit ? fwd_word : rd_data;
    // A counter never written holds its preset value.
    if (cnt_written[addr]) begin
      cnt_eff = word[WW-1:PW];
    end else begin
      cnt_eff = (9'(item.entry_index) < 9'(PRESET_SLOTS)) ? 16'd1 : 16'd0;
    end
    sum = cnt_eff + item.operand;

    rsp.map_reg = '0;
    rsp.mapped  = 1'b0;
    rsp.cval    = '0;
    rsp.status  = vrmf_pkg::ST_OK;
    wr_map      = 1'b0;
    wr_cnt      = 1'b0;

    case (item.command)
      vrmf_pkg::CMD_MAP_READ: begin
        if (!item.no_register) begin
          if (!idx_ok) begin
            rsp.status = vrmf_pkg::ST_RANGE;
          end else if (map_valid[addr]) begin
            rsp.map_reg = vrmf_pkg::phys_t'(word[PW-1:0]);
            rsp.mapped  = 1'b1;
          end
        end
      end
      vrmf_pkg::CMD_MAP_WRITE: begin
        if (item.no_register || !idx_ok || !reg_ok) begin
          rsp.status = vrmf_pkg::ST_RANGE;
        end else begin
          wr_map = 1'b1;
        end
      end
      vrmf_pkg::CMD_COUNTER_ADD: begin
        if (!item.no_register) begin
          if (!idx_ok) begin
            rsp.status = vrmf_pkg::ST_RANGE;
          end else begin
            wr_cnt   = 1'b1;
            rsp.cval = sum;
          end
        end
      end
      vrmf_pkg::CMD_COUNTER_READ: begin
        if (item.no_register || !idx_ok) begin
          rsp.status = vrmf_pkg::ST_RANGE;
        end else begin
          rsp.cval = cnt_eff;
        end
      end
      default: begin
      end
    endcase

    wr_en   = wr_map || wr_cnt;
    // Write back the effective counter, so every write makes it valid.
    wr_word = {(wr_cnt ? sum : cnt_eff), (wr_map ? op_reg : word[PW-1:0])};
  end

  vrmf_ram #(
    .WIDTH (WW),
    .DEPTH (RENAMED_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (fire && wr_en),
    .wr_addr (addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid   <= '0;
      cnt_written <= '0;
      fwd_hit     <= 1'b0;
    end else begin
      if (fire && wr_en) begin
        cnt_written[addr] <= 1'b1;
        if (wr_map) begin
          map_valid[addr] <= 1'b1;
        end
      end
      if (rd_en) begin
        fwd_hit <= fire && wr_en && (addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_word <= wr_word;
    end
  end

`ifndef NO_ASSERTIONS
  a_map_set: assert property (@(posedge clk) disable iff (rst)
    (fire && wr_map) |=> map_valid[$past(addr)])
    else $error("map write did not mark entry mapped");

  a_cnt_set: assert property (@(posedge clk) disable iff (rst)
    (fire && wr_en) |=> cnt_written[$past(addr)])
    else $error("slot write did not mark counter written");

  a_fwd_take: assert property (@(posedge clk) disable iff (rst)
    (rd_en && fire && wr_en && addr == rd_addr) |=> fwd_hit)
    else $error("same-slot access not forwarded");
`endif

endmodule

@@ design/vector_rename_map_free_list.sv @@
// ----------------------------------------------------------------------------
// vector_rename_map_free_list
// Vector register rename store: map table, free list and commit counters.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (cmd_valid/cmd_stall) carries one item per transfer:
//   command, entry_index, no_register and operand_value. The result channel
//   (rsp_valid/rsp_stall) returns exactly one item per command, in order.
//   A taken command is registered into execute, then its result into the
//   registers behind rsp_valid. Throughput: one command per cycle while no
//   result stalls; the slot RAM and free-queue RAM are read when a command
//   is taken and written back when it leaves execute, and a forwarding
//   register covers a command touching the entry the one just ahead wrote.
//   Stall: while a result waits with rsp_stall high, the command in execute
//   holds and cmd_stall goes high; once the result is taken, execute
//   completes and the channel opens again in that same cycle.
//   Reset (rst, synchronous): every map entry unmapped, the free list full
//   with registers in ascending order, counters at their preset values.
//   Valid bits stand in for initial RAM contents, so no clearing pass runs
//   and commands are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module vector_rename_map_free_list #(
  parameter int RENAMED_SLOTS = vrmf_pkg::RENAMED_SLOTS_DEF,
  parameter int PHYS_REGS     = vrmf_pkg::PHYS_REGS_DEF,
  parameter int PRESET_SLOTS  = vrmf_pkg::PRESET_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [vrmf_pkg::CMD_W-1:0]          command,
  input  logic [vrmf_pkg::IDX_W-1:0]          entry_index,
  input  logic                                no_register,
  input  logic signed [vrmf_pkg::OPND_W-1:0]  operand_value,

  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [vrmf_pkg::RES_REG_W-1:0]      result_reg,
  output logic                                reg_mapped,
  output logic signed [vrmf_pkg::CNT_W-1:0]   counter_value,
  output logic                                free_empty,
  output logic [1:0]                          status
);

  // Execute stage.
  logic              ex_valid;
  vrmf_pkg::item_t   ex_item;
  vrmf_pkg::item_t   in_item;

  logic accept;
  logic fire;

  vrmf_pkg::slot_rsp_t slot_rsp;
  vrmf_pkg::fl_rsp_t   fl_rsp;

  vrmf_pkg::phys_t   res_phys;
  vrmf_pkg::status_t status_next;

  // Finish execute whenever the output register is free or being drained.
  assign fire      = ex_valid && !(rsp_valid && rsp_stall);
  assign cmd_stall = ex_valid && rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    in_item.command     = command;
    in_item.entry_index = entry_index;
    in_item.no_register = no_register;
    in_item.operand     = operand_value;
  end

  vrmf_slot_table #(
    .RENAMED_SLOTS (RENAMED_SLOTS),
    .PHYS_REGS     (PHYS_REGS),
    .PRESET_SLOTS  (PRESET_SLOTS)
  ) u_slot_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (entry_index),
    .fire   (fire),
    .item   (ex_item),
    .rsp    (slot_rsp)
  );

  vrmf_free_list #(
    .PHYS_REGS (PHYS_REGS)
  ) u_free_list (
    .clk   (clk),
    .rst   (rst),
    .rd_en (accept),
    .fire  (fire),
    .item  (ex_item),
    .rsp   (fl_rsp)
  );

  // Pick the answering unit by command; unused codes report ok and zeros, but free_empty still follows the free list.
  always_comb begin
    case (ex_item.command)
      vrmf_pkg::CMD_MAP_READ,
      vrmf_pkg::CMD_MAP_WRITE,
      vrmf_pkg::CMD_COUNTER_ADD,
      vrmf_pkg::CMD_COUNTER_READ: begin
        res_phys    = slot_rsp.map_reg;
        status_next = slot_rsp.status;
      end
      vrmf_pkg::CMD_ALLOCATE,
      vrmf_pkg::CMD_RELEASE: begin
        res_phys    = fl_rsp.pop_reg;
        status_next = fl_rsp.status;
      end
      default: begin
        res_phys    = '0;
        status_next = vrmf_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Hold the item in execute until its result can be registered.
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (fire) begin
        ex_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= in_item;
    end
    if (fire) begin
      result_reg    <= res_phys[vrmf_pkg::RES_REG_W-1:0];
      reg_mapped    <= slot_rsp.mapped;
      counter_value <= $signed(slot_rsp.cval);
      free_empty    <= fl_rsp.empty;
      status        <= status_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> ex_valid)
    else $error("accepted command missing from execute");

  a_fire_to_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("finished command produced no result");

  a_exec_hold: assert property (@(posedge clk) disable iff (rst)
    (ex_valid && rsp_valid && rsp_stall) |=> (ex_valid && $stable(ex_item)))
    else $error("execute stage dropped a stalled command");
`endif

endmodule
